[hdl/tmi_pkg.sv]
// ----------------------------------------------------------------------------
// tmi_pkg: shared types and constants for the triclinic minimum image block
// Action codes, register indexes, reset values and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package tmi_pkg;

	typedef enum logic [2:0] {
		ACT_TO_REAL  = 3'd0,
		ACT_TO_FRAC  = 3'd1,
		ACT_IMAGE    = 3'd2,
		ACT_VECTOR   = 3'd3,
		ACT_DIST     = 3'd4,
		ACT_DIST_SQ  = 3'd5
	} action_t;

	localparam int NUM_REGS   = 6;
	localparam int REG_IDX_W  = 3;
	localparam int REG_W      = 64;
	localparam int ENTRY_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_FWD_XX_XY = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FWD_XZ_YY = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FWD_YZ_ZZ = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INV_XX_XY = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INV_XZ_YY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INV_YZ_ZZ = 3'd5;

	// Identity matrix in Q16.16 for the cell and Q2.30 for its inverse.
	localparam logic [REG_W-1:0] RST_FWD_XX_XY = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] RST_FWD_XZ_YY = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_FWD_YZ_ZZ = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_INV_XX_XY = 64'h0000_0000_4000_0000;
	localparam logic [REG_W-1:0] RST_INV_XZ_YY = 64'h4000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_INV_YZ_ZZ = 64'h4000_0000_0000_0000;

	localparam int SH_TO_REAL = 16;
	localparam int SH_TO_FRAC = 30;
	localparam int SH_WRAP    = 18;
	localparam int SH_BACK    = 28;

	localparam int FRAC_W     = 28;   // wrapped fractional value, signed Q0.28
	localparam int BACK_W     = 62;   // sum of three cell entry by fraction products
	localparam int VEC_W      = 34;   // unsaturated real minimum vector
	localparam int SQ_W       = 2 * VEC_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int SCALAR_W   = 64;
	localparam int ROOT_BITS  = (SUM_W + 32) / 2;

endpackage

[hdl/tmi_sqrt.sv]
// ----------------------------------------------------------------------------
// tmi_sqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence, with side data that
// travels alongside. All stages advance together under a common enable.
// ----------------------------------------------------------------------------
module tmi_sqrt #(
	parameter int RB     = 51,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RB-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [RB-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [RB];
	logic [RB+1:0]     rem_s  [RB];
	logic [RB-1:0]     root_s [RB];
	logic [2*RB-1:0]   x_s    [RB];
	logic [SIDE_W-1:0] side_s [RB];

	logic              vld_in  [RB];
	logic [RB+1:0]     rem_in  [RB];
	logic [RB-1:0]     root_in [RB];
	logic [2*RB-1:0]   x_in    [RB];
	logic [SIDE_W-1:0] side_i  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_step
		logic [RB+3:0] cand;
		logic [RB+3:0] trial;
		logic [RB+3:0] diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_in[k]  = in_valid;
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
			assign x_in[k]    = radicand;
			assign side_i[k]  = side_in;
		end else begin : g_next
			assign vld_in[k]  = vld_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign root_in[k] = root_s[k-1];
			assign x_in[k]    = x_s[k-1];
			assign side_i[k]  = side_s[k-1];
		end

		assign cand  = {rem_in[k], x_in[k][2*RB-1:2*RB-2]};
		assign trial = {2'b00, root_in[k], 2'b01};
		assign ge    = cand >= trial;
		assign diff  = cand - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in[k];
			end
		end

		// The remainder never exceeds twice the partial root, so it fits RB+2 bits.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RB+1:0] : cand[RB+1:0];
				root_s[k] <= {root_in[k][RB-2:0], ge};
				x_s[k]    <= {x_in[k][2*RB-3:0], 2'b00};
				side_s[k] <= side_i[k];
			end
		end
	end

	assign out_valid = vld_s[RB-1];
	assign root      = root_s[RB-1];
	assign side_out  = side_s[RB-1];

endmodule

[hdl/triclinic_minimum_image.sv]
// ----------------------------------------------------------------------------
// triclinic_minimum_image: periodic triclinic cell geometry in fixed point
// Converts points between real and fractional space and finds minimum image
// vectors, distances and squared distances under periodic boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the item channel (item_valid/item_ready) with an action
//   code and two points; each item gives one transaction on the result
//   channel (result_valid/result_ready). The cell matrix and its inverse are
//   loaded through the cfg_we/cfg_index/cfg_data write port while the block
//   is idle; the user must keep to this, as the block does not enforce it.
//   Writes to unknown indexes are dropped. Nine arithmetic stages (two matrix
//   multiplies, rounding, wrap, squaring) are followed by a 51-stage square
//   root that resolves one root bit per stage. Every action takes the same
//   path, so results leave in order. Throughput is one item per cycle unless
//   a stall holds it. Reset clears all valid bits and loads identity matrices.
//   When the receiver holds result_ready low with a result waiting, the
//   whole pipeline freezes and item_ready drops; nothing is lost or repeated.
//   Empty stages do not fill during a stall, since every stage shares one enable.
// ----------------------------------------------------------------------------
module triclinic_minimum_image #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tmi_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tmi_pkg::REG_W-1:0]     cfg_data,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [2:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [COORD_WIDTH-1:0] vec_x,
	output logic signed [COORD_WIDTH-1:0] vec_y,
	output logic signed [COORD_WIDTH-1:0] vec_z,
	output logic [tmi_pkg::SCALAR_W-1:0]  scalar,
	output logic                          saturated
);

	localparam int W      = COORD_WIDTH;
	localparam int OW     = W + 1;
	localparam int PW     = OW + tmi_pkg::ENTRY_W;
	localparam int AW     = PW + 2;
	localparam int EW     = W + 19;
	localparam int FW     = tmi_pkg::FRAC_W;
	localparam int QW     = tmi_pkg::ENTRY_W + FW;
	localparam int BW     = tmi_pkg::BACK_W;
	localparam int VW     = tmi_pkg::VEC_W;
	localparam int SQW    = tmi_pkg::SQ_W;
	localparam int SW     = tmi_pkg::SUM_W;
	localparam int SCW    = tmi_pkg::SCALAR_W;
	localparam int RB     = tmi_pkg::ROOT_BITS;
	localparam int SIDE_W = 3 * W + SCW + 2;

	// Returns {clip, value} for a wide signed value clamped into W bits.
	function automatic logic [W:0] sat_fn(input logic signed [EW-1:0] x);
		logic [EW-W:0] top;
		logic [W-1:0]  val;
		logic          clip;
		top  = x[EW-1:W-1];
		clip = !((&top) || !(|top));
		if (!clip) begin
			val = x[W-1:0];
		end else if (x[EW-1]) begin
			val = {1'b1, {(W-1){1'b0}}};
		end else begin
			val = {1'b0, {(W-1){1'b1}}};
		end
		return {clip, val};
	endfunction

	logic adv;
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	// ---------------- configuration registers ----------------
	logic [tmi_pkg::REG_W-1:0] cfg_q [tmi_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[tmi_pkg::REG_FWD_XX_XY] <= tmi_pkg::RST_FWD_XX_XY;
			cfg_q[tmi_pkg::REG_FWD_XZ_YY] <= tmi_pkg::RST_FWD_XZ_YY;
			cfg_q[tmi_pkg::REG_FWD_YZ_ZZ] <= tmi_pkg::RST_FWD_YZ_ZZ;
			cfg_q[tmi_pkg::REG_INV_XX_XY] <= tmi_pkg::RST_INV_XX_XY;
			cfg_q[tmi_pkg::REG_INV_XZ_YY] <= tmi_pkg::RST_INV_XZ_YY;
			cfg_q[tmi_pkg::REG_INV_YZ_ZZ] <= tmi_pkg::RST_INV_YZ_ZZ;
		end else if (cfg_we && (cfg_index <= tmi_pkg::REG_INV_YZ_ZZ)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Entries in order xx, xy, xz, yy, yz, zz.
	logic signed [31:0] mf [6];
	logic signed [31:0] mi [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			mf[k] = cfg_q[k / 2][32 * (k % 2) +: 32];
			mi[k] = cfg_q[3 + k / 2][32 * (k % 2) +: 32];
		end
	end

	// ---------------- stage 1: operand selection ----------------
	logic                  v_s1;
	logic [2:0]            act_s1;
	logic                  use_inv_s1;
	logic signed [OW-1:0]  op_s1 [3];
	logic signed [W-1:0]   b_s1  [3];

	logic signed [W-1:0]   fa [3];
	logic signed [W-1:0]   fb [3];
	logic signed [OW-1:0]  op_n [3];

	assign fa[0] = first_x;
	assign fa[1] = first_y;
	assign fa[2] = first_z;
	assign fb[0] = second_x;
	assign fb[1] = second_y;
	assign fb[2] = second_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (action == tmi_pkg::ACT_TO_REAL || action == tmi_pkg::ACT_TO_FRAC) begin
				op_n[j] = OW'(fa[j]);
			end else if (action == tmi_pkg::ACT_IMAGE) begin
				op_n[j] = OW'(fa[j]) - OW'(fb[j]);
			end else begin
				op_n[j] = OW'(fb[j]) - OW'(fa[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1     <= action;
			use_inv_s1 <= action != tmi_pkg::ACT_TO_REAL;
			op_s1      <= op_n;
			b_s1       <= fb;
		end
	end

	// ---------------- stage 2: first matrix products ----------------
	logic                  v_s2;
	logic [2:0]            act_s2;
	logic signed [PW-1:0]  p_s2 [6];
	logic signed [W-1:0]   b_s2 [3];
	logic signed [31:0]    msel [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			msel[k] = use_inv_s1 ? mi[k] : mf[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2  <= act_s1;
			b_s2    <= b_s1;
			p_s2[0] <= msel[0] * op_s1[0];
			p_s2[1] <= msel[1] * op_s1[1];
			p_s2[2] <= msel[2] * op_s1[2];
			p_s2[3] <= msel[3] * op_s1[1];
			p_s2[4] <= msel[4] * op_s1[2];
			p_s2[5] <= msel[5] * op_s1[2];
		end
	end

	// ---------------- stage 3: row sums with rounding offset ----------------
	logic                  v_s3;
	logic [2:0]            act_s3;
	logic signed [AW-1:0]  acc_s3 [3];
	logic signed [W-1:0]   b_s3 [3];
	logic signed [AW-1:0]  rc;

	always_comb begin
		if (act_s2 == tmi_pkg::ACT_TO_REAL) begin
			rc = AW'(1) <<< (tmi_pkg::SH_TO_REAL - 1);
		end else if (act_s2 == tmi_pkg::ACT_TO_FRAC) begin
			rc = AW'(1) <<< (tmi_pkg::SH_TO_FRAC - 1);
		end else begin
			rc = AW'(1) <<< (tmi_pkg::SH_WRAP - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3    <= act_s2;
			b_s3      <= b_s2;
			acc_s3[0] <= AW'(p_s2[0]) + AW'(p_s2[1]) + AW'(p_s2[2]) + rc;
			acc_s3[1] <= AW'(p_s2[3]) + AW'(p_s2[4]) + rc;
			acc_s3[2] <= AW'(p_s2[5]) + rc;
		end
	end

	// ---------------- stage 4: shift, saturate, wrap ----------------
	logic                  v_s4;
	logic [2:0]            act_s4;
	logic signed [W-1:0]   b_s4   [3];
	logic signed [FW-1:0]  w_s4   [3];
	logic signed [W-1:0]   vec_s4 [3];
	logic                  sat_s4;

	logic signed [W-1:0]   vec4_n [3];
	logic                  sat4_n;
	logic signed [EW-1:0]  sh4;
	logic [W:0]            r4;

	always_comb begin
		sat4_n = 1'b0;
		for (int j = 0; j < 3; j++) begin
			if (act_s3 == tmi_pkg::ACT_TO_REAL) begin
				sh4 = acc_s3[j][AW-1:tmi_pkg::SH_TO_REAL];
			end else begin
				sh4 = EW'(signed'(acc_s3[j][AW-1:tmi_pkg::SH_TO_FRAC]));
			end
			r4 = sat_fn(sh4);
			if (act_s3 == tmi_pkg::ACT_TO_REAL || act_s3 == tmi_pkg::ACT_TO_FRAC) begin
				vec4_n[j] = r4[W-1:0];
				sat4_n    = sat4_n | r4[W];
			end else begin
				vec4_n[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	// Taking the rounded fraction modulo one is just a signed view of its low bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4 <= act_s3;
			b_s4   <= b_s3;
			vec_s4 <= vec4_n;
			sat_s4 <= sat4_n;
			for (int j = 0; j < 3; j++) begin
				w_s4[j] <= acc_s3[j][tmi_pkg::SH_WRAP + FW - 1:tmi_pkg::SH_WRAP];
			end
		end
	end

	// ---------------- stage 5: back to real space products ----------------
	logic                  v_s5;
	logic [2:0]            act_s5;
	logic signed [W-1:0]   b_s5   [3];
	logic signed [W-1:0]   vec_s5 [3];
	logic                  sat_s5;
	logic signed [QW-1:0]  q_s5   [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s5  <= act_s4;
			b_s5    <= b_s4;
			vec_s5  <= vec_s4;
			sat_s5  <= sat_s4;
			q_s5[0] <= mf[0] * w_s4[0];
			q_s5[1] <= mf[1] * w_s4[1];
			q_s5[2] <= mf[2] * w_s4[2];
			q_s5[3] <= mf[3] * w_s4[1];
			q_s5[4] <= mf[4] * w_s4[2];
			q_s5[5] <= mf[5] * w_s4[2];
		end
	end

	// ---------------- stage 6: real minimum vector ----------------
	logic                  v_s6;
	logic [2:0]            act_s6;
	logic signed [W-1:0]   b_s6   [3];
	logic signed [W-1:0]   vec_s6 [3];
	logic                  sat_s6;
	logic signed [VW-1:0]  v6_s6  [3];
	logic signed [BW-1:0]  bsum   [3];
	logic signed [BW-1:0]  brc;

	assign brc = BW'(1) <<< (tmi_pkg::SH_BACK - 1);

	always_comb begin
		bsum[0] = BW'(q_s5[0]) + BW'(q_s5[1]) + BW'(q_s5[2]) + brc;
		bsum[1] = BW'(q_s5[3]) + BW'(q_s5[4]) + brc;
		bsum[2] = BW'(q_s5[5]) + brc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s6 <= act_s5;
			b_s6   <= b_s5;
			vec_s6 <= vec_s5;
			sat_s6 <= sat_s5;
			for (int j = 0; j < 3; j++) begin
				v6_s6[j] <= bsum[j][BW-1:tmi_pkg::SH_BACK];
			end
		end
	end

	// ---------------- stage 7: image and vector outputs, magnitudes ----------------
	logic                  v_s7;
	logic [2:0]            act_s7;
	logic signed [W-1:0]   vec_s7 [3];
	logic                  sat_s7;
	logic [VW-1:0]         mag_s7 [3];

	logic signed [W-1:0]   vec7_n [3];
	logic                  sat7_n;
	logic [VW-1:0]         mag7_n [3];
	logic signed [EW-1:0]  img7;
	logic [W:0]            ri7;
	logic [W:0]            rv7;

	always_comb begin
		sat7_n = sat_s6;
		for (int j = 0; j < 3; j++) begin
			img7 = EW'(v6_s6[j]) + EW'(b_s6[j]);
			ri7  = sat_fn(img7);
			rv7  = sat_fn(EW'(v6_s6[j]));
			mag7_n[j] = v6_s6[j][VW-1] ? VW'(-v6_s6[j]) : VW'(v6_s6[j]);
			if (act_s6 == tmi_pkg::ACT_IMAGE) begin
				vec7_n[j] = ri7[W-1:0];
				sat7_n    = sat7_n | ri7[W];
			end else if (act_s6 == tmi_pkg::ACT_VECTOR) begin
				vec7_n[j] = rv7[W-1:0];
				sat7_n    = sat7_n | rv7[W];
			end else begin
				vec7_n[j] = vec_s6[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s7 <= act_s6;
			vec_s7 <= vec7_n;
			sat_s7 <= sat7_n;
			mag_s7 <= mag7_n;
		end
	end

	// ---------------- stage 8: squares ----------------
	logic                  v_s8;
	logic [2:0]            act_s8;
	logic signed [W-1:0]   vec_s8 [3];
	logic                  sat_s8;
	logic [SQW-1:0]        sq_s8  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s8 <= act_s7;
			vec_s8 <= vec_s7;
			sat_s8 <= sat_s7;
			for (int j = 0; j < 3; j++) begin
				sq_s8[j] <= mag_s7[j] * mag_s7[j];
			end
		end
	end

	// ---------------- stage 9: squared distance ----------------
	logic                  v_s9;
	logic [2:0]            act_s9;
	logic signed [W-1:0]   vec_s9 [3];
	logic                  sat_s9;
	logic [SCW-1:0]        scalar_s9;
	logic [SW-1:0]         sum_s9;

	logic [SW-1:0]         sum9_n;
	logic                  ovf9;
	logic                  is_dist8;
	logic                  is_sq8;

	assign sum9_n   = SW'(sq_s8[0]) + SW'(sq_s8[1]) + SW'(sq_s8[2]);
	assign ovf9     = |sum9_n[SW-1:SCW];
	assign is_dist8 = act_s8 == tmi_pkg::ACT_DIST;
	assign is_sq8   = act_s8 == tmi_pkg::ACT_DIST_SQ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s9 <= act_s8;
			sum_s9 <= sum9_n;
			if (is_dist8 || is_sq8) begin
				vec_s9[0] <= '0;
				vec_s9[1] <= '0;
				vec_s9[2] <= '0;
			end else begin
				vec_s9 <= vec_s8;
			end
			if (is_sq8) begin
				scalar_s9 <= ovf9 ? '1 : sum9_n[SCW-1:0];
				sat_s9    <= ovf9;
			end else begin
				scalar_s9 <= '0;
				sat_s9    <= sat_s8;
			end
		end
	end

	// ---------------- square root and output ----------------
	logic [SIDE_W-1:0] side_in;
	logic [SIDE_W-1:0] side_out;
	logic [RB-1:0]     root;
	logic [2*RB-1:0]   radicand;
	logic              out_dist;

	assign radicand = {sum_s9, 32'b0};
	assign side_in  = {act_s9 == tmi_pkg::ACT_DIST, sat_s9, scalar_s9,
	                   vec_s9[2], vec_s9[1], vec_s9[0]};

	tmi_sqrt #(
		.RB     (RB),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s9),
		.radicand  (radicand),
		.side_in   (side_in),
		.out_valid (result_valid),
		.root      (root),
		.side_out  (side_out)
	);

	assign out_dist  = side_out[SIDE_W-1];
	assign saturated = side_out[SIDE_W-2];
	assign scalar    = out_dist ? SCW'(root) : side_out[3*W +: SCW];
	assign vec_z     = side_out[2*W +: W];
	assign vec_y     = side_out[W +: W];
	assign vec_x     = side_out[0 +: W];

	// ---------------- assertions ----------------
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && act_s9 > 3'(tmi_pkg::ACT_DIST_SQ)) |->
		(vec_s9[0] == '0 && vec_s9[1] == '0 && vec_s9[2] == '0
		 && scalar_s9 == '0 && !sat_s9))
		else $error("undefined action produced a nonzero result");

	a_dist_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && (act_s9 == tmi_pkg::ACT_DIST || act_s9 == tmi_pkg::ACT_DIST_SQ)) |->
		(vec_s9[0] == '0 && vec_s9[1] == '0 && vec_s9[2] == '0))
		else $error("distance action carries a nonzero vector");

	a_dist_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_dist) |-> !saturated)
		else $error("distance transaction flagged as saturated");

endmodule
